FILE: rtl/core/sfq_pkg.sv
`timescale 1ns / 1ps
package sfq_pkg;
	localparam int DEPTH = 64;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;

	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [31:0] num;
		logic [9:0]  fh;
		logic [31:0] key;
		logic [31:0] quantum;
	} rec_t;

	localparam int RW = $bits(rec_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_PUT,
		S_POP,
		S_DONE
	} state_t;
endpackage

FILE: rtl/core/sfq_ram.sv
`timescale 1ns / 1ps
module sfq_ram #(
	parameter int W = 8,
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wr_addr,
	input  logic [W-1:0]  wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [W-1:0]  rd_data
);
	logic [W-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

FILE: rtl/core/shortest_first_request_queue.sv
`timescale 1ns / 1ps
// Shortest-first request queue, 64 records held in one synchronous RAM.
// Input channel (in_valid/in_stall) takes one command item: kind selects
// append at tail, insert sorted by bytes_left (stable among equal keys) or
// remove head. Output channel (out_valid/out_stall) returns one result item
// per command: status, the removed record when record_valid is set, and the
// occupancy after the command.
// One command is worked at a time; the RAM read/write port sets the pace.
// Append writes at the tail and remove reads the head before the result;
// rejected and ignored commands go straight to the result. A sorted insert
// reads entries from the head until one has a larger key or the tail is met;
// when it lands ahead of an entry, the entries from the tail back to it move up.
// The result sits in an output register; the next command is accepted while
// it waits. When the receiver stalls, the output holds and a finished
// second result waits in its own register, holding off further commands.
// Reset (arst_n low) empties the queue; RAM contents are not cleared.
module shortest_first_request_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              kind,
	input  logic [31:0]             request_number,
	input  logic [9:0]              file_handle,
	input  logic [31:0]             bytes_left,
	input  logic [31:0]             quantum,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic                    record_valid,
	output logic [31:0]             out_request_number,
	output logic [9:0]              out_file_handle,
	output logic [31:0]             out_bytes_left,
	output logic [31:0]             out_quantum,
	output logic [sfq_pkg::CW-1:0]  occupancy
);
	sfq_pkg::state_t state_q, state_d;
	logic [sfq_pkg::AW-1:0] head_q, idx_q, pos_q, src_q;
	logic [sfq_pkg::CW-1:0] count_q;
	logic [1:0] kind_q;
	sfq_pkg::rec_t item_q, res_rec_q, out_rec_q, rd_data, wr_data;
	logic [1:0] res_status_q, out_status_q;
	logic res_valid_q, out_rec_valid_q, out_valid_q;
	logic [sfq_pkg::CW-1:0] out_count_q;
	logic we;
	logic [sfq_pkg::AW-1:0] wr_addr, rd_addr;
	logic accept, out_free, full, hit, last;

	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != sfq_pkg::S_IDLE);
	assign full = (count_q == sfq_pkg::CW'(sfq_pkg::DEPTH));
	assign hit = (rd_data.key > item_q.key);
	assign last = ({1'b0, idx_q} + sfq_pkg::CW'(1)) == count_q;

	sfq_ram #(.W(sfq_pkg::RW), .AW(sfq_pkg::AW)) u_ram (
		.clk(clk), .we(we), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_addr(rd_addr), .rd_data(rd_data)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			sfq_pkg::S_IDLE: begin
				if (accept) begin
					case (kind)
						sfq_pkg::KIND_APPEND: state_d = full ? sfq_pkg::S_DONE : sfq_pkg::S_PUT;
						sfq_pkg::KIND_INSERT: begin
							if (full) state_d = sfq_pkg::S_DONE;
							else if (count_q == '0) state_d = sfq_pkg::S_PUT;
							else state_d = sfq_pkg::S_SCAN;
						end
						sfq_pkg::KIND_REMOVE: state_d = (count_q == '0) ? sfq_pkg::S_DONE : sfq_pkg::S_POP;
						default: state_d = sfq_pkg::S_DONE;
					endcase
				end
			end
			sfq_pkg::S_SCAN: begin
				if (hit) state_d = sfq_pkg::S_SHIFT;
				else if (last) state_d = sfq_pkg::S_PUT;
			end
			sfq_pkg::S_SHIFT: if (src_q == pos_q) state_d = sfq_pkg::S_PUT;
			sfq_pkg::S_PUT: state_d = sfq_pkg::S_DONE;
			sfq_pkg::S_POP: state_d = sfq_pkg::S_DONE;
			sfq_pkg::S_DONE: if (out_free) state_d = sfq_pkg::S_IDLE;
			default: state_d = sfq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		wr_addr = head_q + pos_q;
		wr_data = item_q;
		rd_addr = head_q;
		case (state_q)
			sfq_pkg::S_SCAN: begin
				if (hit) rd_addr = head_q + count_q[sfq_pkg::AW-1:0] - sfq_pkg::AW'(1);
				else rd_addr = head_q + idx_q + sfq_pkg::AW'(1);
			end
			sfq_pkg::S_SHIFT: begin
				we = 1'b1;
				wr_addr = head_q + src_q + sfq_pkg::AW'(1);
				wr_data = rd_data;
				rd_addr = head_q + src_q - sfq_pkg::AW'(1);
			end
			sfq_pkg::S_PUT: we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfq_pkg::S_IDLE;
			head_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sfq_pkg::S_PUT) count_q <= count_q + sfq_pkg::CW'(1);
			if (state_q == sfq_pkg::S_POP) begin
				count_q <= count_q - sfq_pkg::CW'(1);
				head_q <= head_q + sfq_pkg::AW'(1);
			end
			if (state_q == sfq_pkg::S_DONE && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sfq_pkg::S_IDLE: begin
				if (accept) begin
					kind_q <= kind;
					item_q <= '{num: request_number, fh: file_handle, key: bytes_left,
						quantum: quantum};
					idx_q <= '0;
					pos_q <= count_q[sfq_pkg::AW-1:0];
					res_valid_q <= 1'b0;
					res_rec_q <= '0;
					res_status_q <= sfq_pkg::STAT_DONE;
					if ((kind == sfq_pkg::KIND_APPEND || kind == sfq_pkg::KIND_INSERT) && full)
						res_status_q <= sfq_pkg::STAT_FULL;
					if (kind == sfq_pkg::KIND_REMOVE && count_q == '0)
						res_status_q <= sfq_pkg::STAT_EMPTY;
				end
			end
			sfq_pkg::S_SCAN: begin
				if (hit) begin
					pos_q <= idx_q;
					src_q <= count_q[sfq_pkg::AW-1:0] - sfq_pkg::AW'(1);
				end
				idx_q <= idx_q + sfq_pkg::AW'(1);
			end
			sfq_pkg::S_SHIFT: src_q <= src_q - sfq_pkg::AW'(1);
			sfq_pkg::S_POP: begin
				res_rec_q <= rd_data;
				res_valid_q <= (kind_q == sfq_pkg::KIND_REMOVE);
			end
			sfq_pkg::S_DONE: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_rec_valid_q <= res_valid_q;
					out_rec_q <= res_rec_q;
					out_count_q <= count_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign record_valid = out_rec_valid_q;
	assign out_request_number = out_rec_q.num;
	assign out_file_handle = out_rec_q.fh;
	assign out_bytes_left = out_rec_q.key;
	assign out_quantum = out_rec_q.quantum;
	assign occupancy = out_count_q;
endmodule

FILE: rtl/core/sfq_checker.sv
`timescale 1ns / 1ps
module sfq_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [1:0]             status,
	input logic                   record_valid,
	input logic [31:0]            out_request_number,
	input logic [31:0]            out_bytes_left,
	input logic [sfq_pkg::CW-1:0] occupancy
);
	a_rec_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_valid |-> status == sfq_pkg::STAT_DONE)
		else $error("record returned with failing status");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occupancy <= sfq_pkg::CW'(sfq_pkg::DEPTH))
		else $error("occupancy above depth");

	a_no_rec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !record_valid |-> out_request_number == '0 && out_bytes_left == '0)
		else $error("record fields not zero");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(occupancy))
		else $error("stalled item changed");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == sfq_pkg::STAT_FULL |-> occupancy == sfq_pkg::CW'(sfq_pkg::DEPTH))
		else $error("full status below depth");
endmodule

bind shortest_first_request_queue sfq_checker u_sfq_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.status(status), .record_valid(record_valid),
	.out_request_number(out_request_number), .out_bytes_left(out_bytes_left),
	.occupancy(occupancy)
);
